### hw/rtl/rusph_pkg.sv
// Shared widths, register map and reset values for the unit-sphere ray hit block.
// No dependencies; the interfaces, the top level and the checker import this package.
`timescale 1ns / 1ps
`default_nettype none

package rusph_pkg;

  localparam int PIX_W  = 16;
  localparam int SCR_W  = 12;
  localparam int CD_W   = 16;
  localparam int FOV_W  = 16;
  localparam int OUT_W  = 18;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_SCREEN_WIDTH    = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_CAMERA_DISTANCE = 2'd2;
  localparam logic [1:0] REG_FOV_FACTOR      = 2'd3;

  localparam logic [SCR_W-1:0] RST_SCREEN_WIDTH    = 12'd320;
  localparam logic [SCR_W-1:0] RST_SCREEN_HEIGHT   = 12'd240;
  localparam logic [CD_W-1:0]  RST_CAMERA_DISTANCE = 16'd768;
  localparam logic [FOV_W-1:0] RST_FOV_FACTOR      = 16'd4096;

  // Datapath widths.
  localparam int DX_W    = 18;  // 2*pixel - 16*size, signed
  localparam int MAGX_W  = 17;  // |dx|
  localparam int AZM_W   = 28;  // |az|
  localparam int L2_W    = 58;  // squared length of the direction
  localparam int LEN_W   = 29;  // floor(sqrt(l2))
  localparam int DVD_W   = 59;  // normalize dividend
  localparam int NQ_W    = 31;  // normalized magnitude, Q30
  localparam int N_W     = 32;  // signed normalized component
  localparam int MMAG_W  = 29;  // |m|, Q20
  localparam int QD_W    = 59;  // quarter discriminant, signed
  localparam int T_W     = 31;  // ray parameter t, signed Q20
  localparam int PROD_W  = 63;  // n*t, signed Q50
  localparam int WIDE_W  = 64;

endpackage

`default_nettype wire

### hw/rtl/rusph_if.sv
// Valid/ready channels of the ray hit block: pixel words in, hit words out.
// Depends on rusph_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rusph_pix_if import rusph_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_x;
  logic [PIX_W-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface rusph_hit_if import rusph_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic signed [OUT_W-1:0] point_x;
  logic signed [OUT_W-1:0] point_y;
  logic signed [OUT_W-1:0] point_z;

  modport source (output valid, output hit, output point_x, output point_y,
                  output point_z, input ready);
  modport sink   (input valid, input hit, input point_x, input point_y,
                  input point_z, output ready);
endinterface

`default_nettype wire

### hw/rtl/rusph_isqrt_pipe.sv
// Pipelined integer square root, one result bit per register stage.
// Carries a side tag along with each word; depends on no other file.
`timescale 1ns / 1ps
`default_nettype none

module rusph_isqrt_pipe #(
  parameter int IN_W  = 58,
  parameter int TAG_W = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [IN_W-1:0]      radicand_i,
  input  logic [TAG_W-1:0]     tag_i,
  output logic                 valid_o,
  output logic [IN_W/2-1:0]    root_o,
  output logic [TAG_W-1:0]     tag_o
);

  localparam int RW = IN_W / 2;

  logic             vld_q  [RW];
  logic [IN_W-1:0]  rad_q  [RW];
  logic [RW+1:0]    rem_q  [RW];
  logic [RW-1:0]    root_q [RW];
  logic [TAG_W-1:0] tag_q  [RW];

  logic             vld_d  [RW];
  logic [IN_W-1:0]  rad_d  [RW];
  logic [RW+1:0]    rem_d  [RW];
  logic [RW-1:0]    root_d [RW];
  logic [TAG_W-1:0] tag_d  [RW];

  logic             vld_p;
  logic [IN_W-1:0]  rad_p;
  logic [RW+1:0]    rem_p;
  logic [RW-1:0]    root_p;
  logic [TAG_W-1:0] tag_p;
  logic [RW+1:0]    pre;
  logic [RW+1:0]    trial;

  always_comb begin
    vld_p  = 1'b0;
    rad_p  = '0;
    rem_p  = '0;
    root_p = '0;
    tag_p  = '0;
    pre    = '0;
    trial  = '0;
    for (int k = 0; k < RW; k++) begin
      if (k == 0) begin
        vld_p  = valid_i;
        rad_p  = radicand_i;
        rem_p  = '0;
        root_p = '0;
        tag_p  = tag_i;
      end else begin
        vld_p  = vld_q[k-1];
        rad_p  = rad_q[k-1];
        rem_p  = rem_q[k-1];
        root_p = root_q[k-1];
        tag_p  = tag_q[k-1];
      end
      // Bring down the next two radicand bits and try the next root bit.
      pre   = {rem_p[RW-1:0], rad_p[IN_W-1 -: 2]};
      trial = {root_p, 2'b01};
      vld_d[k] = vld_p;
      rad_d[k] = rad_p << 2;
      tag_d[k] = tag_p;
      if (pre >= trial) begin
        rem_d[k]  = pre - trial;
        root_d[k] = {root_p[RW-2:0], 1'b1};
      end else begin
        rem_d[k]  = pre;
        root_d[k] = {root_p[RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < RW; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      for (int k = 0; k < RW; k++) vld_q[k] <= vld_d[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < RW; k++) begin
        rad_q[k]  <= rad_d[k];
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        tag_q[k]  <= tag_d[k];
      end
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign tag_o   = tag_q[RW-1];

endmodule

`default_nettype wire

### hw/rtl/rusph_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes that
// share one divisor. Carries a side tag; depends on no other file.
`timescale 1ns / 1ps
`default_nettype none

module rusph_div_pipe #(
  parameter int LANES = 3,
  parameter int DVD_W = 59,
  parameter int DIV_W = 29,
  parameter int Q_W   = 31,
  parameter int TAG_W = 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [LANES-1:0][DVD_W-1:0]  dividend_i,
  input  logic [DIV_W-1:0]             divisor_i,
  input  logic [TAG_W-1:0]             tag_i,
  output logic                         valid_o,
  output logic [LANES-1:0][Q_W-1:0]    quotient_o,
  output logic [TAG_W-1:0]             tag_o
);

  // The caller guarantees dividend < divisor * 2^Q_W, so the upper part of the
  // dividend is already a valid partial remainder.
  logic             vld_q [Q_W];
  logic [DIV_W-1:0] dsr_q [Q_W];
  logic [TAG_W-1:0] tag_q [Q_W];
  logic [DIV_W-1:0] rem_q [Q_W][LANES];
  logic [Q_W-1:0]   low_q [Q_W][LANES];
  logic [Q_W-1:0]   quo_q [Q_W][LANES];

  logic             vld_d [Q_W];
  logic [DIV_W-1:0] dsr_d [Q_W];
  logic [TAG_W-1:0] tag_d [Q_W];
  logic [DIV_W-1:0] rem_d [Q_W][LANES];
  logic [Q_W-1:0]   low_d [Q_W][LANES];
  logic [Q_W-1:0]   quo_d [Q_W][LANES];

  logic [DIV_W-1:0] rem_p;
  logic [Q_W-1:0]   low_p;
  logic [Q_W-1:0]   quo_p;
  logic [DIV_W:0]   pre;

  always_comb begin
    rem_p = '0;
    low_p = '0;
    quo_p = '0;
    pre   = '0;
    for (int k = 0; k < Q_W; k++) begin
      if (k == 0) begin
        vld_d[k] = valid_i;
        dsr_d[k] = divisor_i;
        tag_d[k] = tag_i;
      end else begin
        vld_d[k] = vld_q[k-1];
        dsr_d[k] = dsr_q[k-1];
        tag_d[k] = tag_q[k-1];
      end
      for (int l = 0; l < LANES; l++) begin
        if (k == 0) begin
          rem_p = DIV_W'(dividend_i[l] >> Q_W);
          low_p = dividend_i[l][Q_W-1:0];
          quo_p = '0;
        end else begin
          rem_p = rem_q[k-1][l];
          low_p = low_q[k-1][l];
          quo_p = quo_q[k-1][l];
        end
        pre = {rem_p, low_p[Q_W-1]};
        low_d[k][l] = low_p << 1;
        if (pre >= {1'b0, dsr_d[k]}) begin
          rem_d[k][l] = DIV_W'(pre - {1'b0, dsr_d[k]});
          quo_d[k][l] = {quo_p[Q_W-2:0], 1'b1};
        end else begin
          rem_d[k][l] = pre[DIV_W-1:0];
          quo_d[k][l] = {quo_p[Q_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Q_W; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      for (int k = 0; k < Q_W; k++) vld_q[k] <= vld_d[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < Q_W; k++) begin
        dsr_q[k] <= dsr_d[k];
        tag_q[k] <= tag_d[k];
        for (int l = 0; l < LANES; l++) begin
          rem_q[k][l] <= rem_d[k][l];
          low_q[k][l] <= low_d[k][l];
          quo_q[k][l] <= quo_d[k][l];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) quotient_o[l] = quo_q[Q_W-1][l];
  end

  assign valid_o = vld_q[Q_W-1];
  assign tag_o   = tag_q[Q_W-1];

endmodule

`default_nettype wire

### hw/rtl/ray_unit_sphere_hit_unit.sv
// Top level of the unit-sphere ray hit block: register port and datapath.
// Depends on rusph_pkg, rusph_if, rusph_isqrt_pipe and rusph_div_pipe.
//
// Each pixel word (Q12.4 x and y) casts a ray from a camera on the z axis at
// camera_distance (Q8.8) towards a sphere of radius one at the origin and
// returns one result word: hit, and the near intersection point in signed
// fixed point with OUT_FRAC_BITS fraction bits, saturated to +-1.0 and zero on
// a miss. The block takes one pixel word per clock while pixel ready is high
// and returns results in order. Its stages are the two square-root pipelines
// (29 stages each, one root bit per stage) and the normalizing divider (31
// stages, one quotient bit per stage, three lanes sharing the length as
// divisor), plus 13 stages of multiply, add and rounding. A result that is not
// taken holds the output register, and the whole pipeline stalls with it
// while pixel ready is low. The user must write registers over the APB port
// only while no pixel word is in flight; the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module ray_unit_sphere_hit_unit import rusph_pkg::*; #(
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rusph_pix_if.sink         pixel_i,
  rusph_hit_if.source       result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int SH    = 50 - OUT_FRAC_BITS;
  localparam int RND_W = WIDE_W - SH;
  localparam int VW    = OUT_FRAC_BITS + 2;
  localparam logic [WIDE_W-1:0] HALF    = WIDE_W'(64'd1 << (SH - 1));
  localparam logic [RND_W-1:0]  SAT_LIM = RND_W'(64'd1 << OUT_FRAC_BITS);

  // ---------------------------------------------------------------- registers
  logic [SCR_W-1:0] sw_q, sh_q;
  logic [CD_W-1:0]  cd_q;
  logic [FOV_W-1:0] fov_q;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q  <= RST_SCREEN_WIDTH;
      sh_q  <= RST_SCREEN_HEIGHT;
      cd_q  <= RST_CAMERA_DISTANCE;
      fov_q <= RST_FOV_FACTOR;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_SCREEN_WIDTH:    sw_q  <= pwdata[SCR_W-1:0];
        REG_SCREEN_HEIGHT:   sh_q  <= pwdata[SCR_W-1:0];
        REG_CAMERA_DISTANCE: cd_q  <= pwdata[CD_W-1:0];
        REG_FOV_FACTOR:      fov_q <= pwdata[FOV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SCREEN_WIDTH:    prdata = APB_DW'(sw_q);
      REG_SCREEN_HEIGHT:   prdata = APB_DW'(sh_q);
      REG_CAMERA_DISTANCE: prdata = APB_DW'(cd_q);
      REG_FOV_FACTOR:      prdata = APB_DW'(fov_q);
      default:             prdata = '0;
    endcase
  end

  // ------------------------------------------------------------ flow control
  // Every stage moves together; only a full, untaken output register stops it.
  logic en;
  logic v13_q;

  assign en            = !v13_q || result_o.ready;
  assign pixel_i.ready = en;

  // Stage 1: offsets from the screen centre and depth magnitude.
  logic                    v1_q;
  logic signed [DX_W-1:0]  dx1_q, dy1_q;
  logic [AZM_W-1:0]        azm1_q;

  // Stage 2: magnitudes and squares.
  logic                    v2_q, sx2_q, sy2_q;
  logic [MAGX_W-1:0]       magx2_q, magy2_q;
  logic [AZM_W-1:0]        azm2_q;
  logic [2*MAGX_W-1:0]     sqx2_q, sqy2_q;
  logic [2*AZM_W-1:0]      sqz2_q;

  // Stage 3: squared length.
  logic                    v3_q;
  logic [L2_W-1:0]         l23_q;
  logic [63:0]             tag3_q;

  // Square root of the length.
  logic                    vr1;
  logic [LEN_W-1:0]        len_r1;
  logic [63:0]             tag_r1;

  // Stage 4: dividends of the normalization.
  logic                    v4_q, sx4_q, sy4_q, deg4_q;
  logic [2:0][DVD_W-1:0]   dvd4_q;
  logic [LEN_W-1:0]        len4_q;

  // Divider outputs.
  logic                    vdv;
  logic [2:0][NQ_W-1:0]    quo_dv;
  logic [2:0]              tag_dv;

  // Stages 5 to 8: m = dz*v and the quarter discriminant.
  logic                    v5_q, deg5_q;
  logic signed [N_W-1:0]   nx5_q, ny5_q;
  logic [NQ_W-1:0]         qz5_q;
  logic [NQ_W+CD_W-1:0]    prodz5_q;

  logic                    v6_q, deg6_q;
  logic signed [N_W-1:0]   nx6_q, ny6_q;
  logic [NQ_W-1:0]         qz6_q;
  logic [MMAG_W-1:0]       mmag6_q;

  logic                    v7_q, deg7_q;
  logic signed [N_W-1:0]   nx7_q, ny7_q;
  logic [NQ_W-1:0]         qz7_q;
  logic [MMAG_W-1:0]       mmag7_q;
  logic [2*MMAG_W-1:0]     mm7_q;
  logic [2*CD_W-1:0]       cc7_q;

  logic                    v8_q, hit8_q;
  logic signed [N_W-1:0]   nx8_q, ny8_q;
  logic [NQ_W-1:0]         qz8_q;
  logic [MMAG_W-1:0]       mmag8_q;
  logic [L2_W-1:0]         rad8_q;
  logic [QD_W-1:0]         q8_d;

  // Square root of the discriminant.
  logic                    vr2;
  logic [LEN_W-1:0]        s_r2;
  logic [124:0]            tag_r2;

  // Stages 9 to 13: t, products, rounding.
  logic                    v9_q, hit9_q;
  logic signed [T_W-1:0]   t9_q;
  logic signed [N_W-1:0]   nx9_q, ny9_q;
  logic [NQ_W-1:0]         qz9_q;

  logic                    v10_q, hit10_q;
  logic signed [PROD_W-1:0] px10_q, py10_q, pz10_q;

  logic                    v11_q, hit11_q;
  logic signed [WIDE_W-1:0] pt11_q [3];

  logic                    v12_q, hit12_q;
  logic [2:0]              sgn12_q;
  logic [WIDE_W-1:0]       mag12_q [3];

  logic                    hit13_q;
  logic [OUT_W-1:0]        pt13_q [3];

  logic [RND_W-1:0]        rnd13 [3];
  logic [VW-1:0]           sat13 [3];
  logic signed [VW-1:0]    val13 [3];

  // -------------------------------------------------------------- valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
      v11_q <= 1'b0;
      v12_q <= 1'b0;
      v13_q <= 1'b0;
    end else if (en) begin
      v1_q  <= pixel_i.valid;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= vr1;
      v5_q  <= vdv;
      v6_q  <= v5_q;
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      v9_q  <= vr2;
      v10_q <= v9_q;
      v11_q <= v10_q;
      v12_q <= v11_q;
      v13_q <= v12_q;
    end
  end

  // ------------------------------------------------------ direction + length
  always_ff @(posedge clk_i) begin
    if (en) begin
      dx1_q  <= signed'({1'b0, pixel_i.pixel_x, 1'b0}) - signed'({2'b00, sw_q, 4'b0000});
      dy1_q  <= signed'({1'b0, pixel_i.pixel_y, 1'b0}) - signed'({2'b00, sh_q, 4'b0000});
      azm1_q <= AZM_W'(sh_q * fov_q);
    end
  end

  logic [MAGX_W-1:0] magx_d, magy_d;
  assign magx_d = dx1_q[DX_W-1] ? MAGX_W'(-dx1_q) : MAGX_W'(dx1_q);
  assign magy_d = dy1_q[DX_W-1] ? MAGX_W'(-dy1_q) : MAGX_W'(dy1_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx2_q   <= dx1_q[DX_W-1];
      sy2_q   <= dy1_q[DX_W-1];
      magx2_q <= magx_d;
      magy2_q <= magy_d;
      azm2_q  <= azm1_q;
      sqx2_q  <= magx_d * magx_d;
      sqy2_q  <= magy_d * magy_d;
      sqz2_q  <= azm1_q * azm1_q;
    end
  end

  // The x and y components carry a factor of 128, hence the 14-bit shift.
  always_ff @(posedge clk_i) begin
    if (en) begin
      l23_q  <= L2_W'({sqx2_q, 14'b0}) + L2_W'({sqy2_q, 14'b0}) + L2_W'(sqz2_q);
      tag3_q <= {sx2_q, sy2_q, magx2_q, magy2_q, azm2_q};
    end
  end

  rusph_isqrt_pipe #(
    .IN_W  (L2_W),
    .TAG_W (64)
  ) u_len_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v3_q),
    .radicand_i (l23_q),
    .tag_i      (tag3_q),
    .valid_o    (vr1),
    .root_o     (len_r1),
    .tag_o      (tag_r1)
  );

  // ----------------------------------------------------------- normalization
  // Rounded quotient: (|a| * 2^30 + len/2) / len.
  always_ff @(posedge clk_i) begin
    if (en) begin
      sx4_q     <= tag_r1[63];
      sy4_q     <= tag_r1[62];
      deg4_q    <= (len_r1 == '0);
      len4_q    <= len_r1;
      dvd4_q[0] <= DVD_W'({tag_r1[61:45], 37'b0}) + DVD_W'(len_r1 >> 1);
      dvd4_q[1] <= DVD_W'({tag_r1[44:28], 37'b0}) + DVD_W'(len_r1 >> 1);
      dvd4_q[2] <= DVD_W'({tag_r1[27:0], 30'b0}) + DVD_W'(len_r1 >> 1);
    end
  end

  rusph_div_pipe #(
    .LANES (3),
    .DVD_W (DVD_W),
    .DIV_W (LEN_W),
    .Q_W   (NQ_W),
    .TAG_W (3)
  ) u_norm_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v4_q),
    .dividend_i (dvd4_q),
    .divisor_i  (len4_q),
    .tag_i      ({sx4_q, sy4_q, deg4_q}),
    .valid_o    (vdv),
    .quotient_o (quo_dv),
    .tag_o      (tag_dv)
  );

  // ------------------------------------------------------------ discriminant
  // The depth component is never positive, so m = -round(|nz| * v / 2^18).
  always_ff @(posedge clk_i) begin
    if (en) begin
      nx5_q    <= tag_dv[2] ? -signed'({1'b0, quo_dv[0]}) : signed'({1'b0, quo_dv[0]});
      ny5_q    <= tag_dv[1] ? -signed'({1'b0, quo_dv[1]}) : signed'({1'b0, quo_dv[1]});
      qz5_q    <= quo_dv[2];
      prodz5_q <= quo_dv[2] * cd_q;
      deg5_q   <= tag_dv[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx6_q   <= nx5_q;
      ny6_q   <= ny5_q;
      qz6_q   <= qz5_q;
      deg6_q  <= deg5_q;
      mmag6_q <= MMAG_W'((prodz5_q + (NQ_W+CD_W)'(1 << 17)) >> 18);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx7_q   <= nx6_q;
      ny7_q   <= ny6_q;
      qz7_q   <= qz6_q;
      deg7_q  <= deg6_q;
      mmag7_q <= mmag6_q;
      mm7_q   <= mmag6_q * mmag6_q;
      cc7_q   <= cd_q * cd_q;
    end
  end

  assign q8_d = QD_W'(mm7_q) - QD_W'({cc7_q, 24'b0}) + (QD_W'(1) << 40);

  // A miss feeds zero to the root so the tag alone decides the result.
  always_ff @(posedge clk_i) begin
    if (en) begin
      nx8_q   <= nx7_q;
      ny8_q   <= ny7_q;
      qz8_q   <= qz7_q;
      mmag8_q <= mmag7_q;
      hit8_q  <= !q8_d[QD_W-1] && !deg7_q;
      rad8_q  <= (!q8_d[QD_W-1] && !deg7_q) ? q8_d[L2_W-1:0] : '0;
    end
  end

  rusph_isqrt_pipe #(
    .IN_W  (L2_W),
    .TAG_W (125)
  ) u_disc_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v8_q),
    .radicand_i (rad8_q),
    .tag_i      ({nx8_q, ny8_q, qz8_q, mmag8_q, hit8_q}),
    .valid_o    (vr2),
    .root_o     (s_r2),
    .tag_o      (tag_r2)
  );

  // ------------------------------------------------------- intersection point
  always_ff @(posedge clk_i) begin
    if (en) begin
      nx9_q  <= signed'(tag_r2[124:93]);
      ny9_q  <= signed'(tag_r2[92:61]);
      qz9_q  <= tag_r2[60:30];
      hit9_q <= tag_r2[0];
      t9_q   <= signed'({2'b00, tag_r2[29:1]}) - signed'({2'b00, s_r2});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit10_q <= hit9_q;
      px10_q  <= nx9_q * t9_q;
      py10_q  <= ny9_q * t9_q;
      pz10_q  <= signed'({1'b0, qz9_q}) * t9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit11_q   <= hit10_q;
      pt11_q[0] <= WIDE_W'(px10_q);
      pt11_q[1] <= WIDE_W'(py10_q);
      pt11_q[2] <= signed'({6'b0, cd_q, 42'b0}) - WIDE_W'(pz10_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit12_q <= hit11_q;
      for (int i = 0; i < 3; i++) begin
        sgn12_q[i] <= pt11_q[i][WIDE_W-1];
        mag12_q[i] <= pt11_q[i][WIDE_W-1] ? WIDE_W'(-pt11_q[i]) : WIDE_W'(pt11_q[i]);
      end
    end
  end

  // Round half away from zero on the magnitude, clamp to 1.0, restore sign.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd13[i] = RND_W'((mag12_q[i] + HALF) >> SH);
      sat13[i] = (rnd13[i] > SAT_LIM) ? VW'(SAT_LIM) : VW'(rnd13[i]);
      val13[i] = sgn12_q[i] ? -signed'(sat13[i]) : signed'(sat13[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit13_q <= hit12_q;
      for (int i = 0; i < 3; i++) begin
        pt13_q[i] <= hit12_q ? OUT_W'(val13[i]) : '0;
      end
    end
  end

  assign result_o.valid   = v13_q;
  assign result_o.hit     = hit13_q;
  assign result_o.point_x = signed'(pt13_q[0]);
  assign result_o.point_y = signed'(pt13_q[1]);
  assign result_o.point_z = signed'(pt13_q[2]);

endmodule

`default_nettype wire

### hw/rtl/rusph_checker.sv
// Port-level checks for the unit-sphere ray hit block and their bind.
// Depends on rusph_pkg and on the top level ray_unit_sphere_hit_unit.
`timescale 1ns / 1ps
`default_nettype none

module rusph_checker import rusph_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic                    hit_i,
  input logic signed [OUT_W-1:0] point_x_i,
  input logic signed [OUT_W-1:0] point_y_i,
  input logic signed [OUT_W-1:0] point_z_i
);

  // A missed ray reports the origin.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !hit_i |-> point_x_i == '0 && point_y_i == '0 && point_z_i == '0)
    else $error("miss word with nonzero point");

  // The pixel side only waits on a result word that is held.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("pixel ready low without a held result word");

  // An ignored pixel word leaves the pipeline, and so the result, frozen.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i && in_valid_i |=>
      out_valid_i && $stable({hit_i, point_x_i, point_y_i, point_z_i}))
    else $error("held result word changed");

endmodule

bind ray_unit_sphere_hit_unit rusph_checker u_rusph_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pixel_i.valid),
  .in_ready_i  (pixel_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .hit_i       (result_o.hit),
  .point_x_i   (result_o.point_x),
  .point_y_i   (result_o.point_y),
  .point_z_i   (result_o.point_z)
);

`default_nettype wire
